// ----- src/ptt_pkg.sv -----
// Package for the periodic task timer table: payload types, codes and control structs.
`timescale 1ns / 1ps

package ptt_pkg;

   // Default number of timer slots
   localparam int NUM_TASKS_DEFAULT = 8;

   // Slots reported in each result mask
   localparam int MASK_W = 8;

   // Counter and field widths
   localparam int COUNT_W = 32;
   localparam int ID_W    = 3;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_SET      = 2'd1,
      KIND_UNSET    = 2'd2,
      KIND_DISPATCH = 2'd3
   } kind_type;

   // Request payload
   typedef struct packed {
      kind_type             kind;
      logic [ID_W-1:0]      task_id;
      logic [COUNT_W-1:0]   repeat_count;
      logic [COUNT_W-1:0]   period_ticks;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [MASK_W-1:0] pending_mask;
      logic [MASK_W-1:0] active_mask;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;    // latch the request, restart slot walk
      logic apply;      // perform set or unset on the latched slot
      logic tick_step;  // process one slot of a tick, advance walk
      logic finish;     // load the response register
   } ptt_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_slot;  // slot walk is on the final slot
      logic rsp_free;   // response register can take a new result
   } ptt_sts_type;

endpackage

// ----- src/ptt_ctrl.sv -----
// Controller state machine for the periodic task timer table.
`timescale 1ns / 1ps

module ptt_ctrl import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  kind_type    req_kind,
   output logic        req_ready,
   input  ptt_sts_type sts,
   output ptt_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_APPLY  = 4'b0010,
      ST_TICK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_kind)
                  KIND_TICK:     state_in = ST_TICK;
                  KIND_SET:      state_in = ST_APPLY;
                  KIND_UNSET:    state_in = ST_APPLY;
                  KIND_DISPATCH: state_in = ST_FINISH;
                  default:       state_in = ST_FINISH;
               endcase
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_TICK: begin
            cmd.tick_step = 1'b1;
            if (sts.last_slot) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result is only loaded when the response register has room
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.rsp_free)
      else $error("result loaded into a full response register");

endmodule

// ----- src/ptt_datapath.sv -----
// Datapath for the periodic task timer table: slot state, slot walk and response register.
`timescale 1ns / 1ps

module ptt_datapath import ptt_pkg::*; #(
   parameter int NUM_TASKS = NUM_TASKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ptt_cmd_type cmd,
   output ptt_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Latched request and slot walk
   req_type            item_ff;
   logic [SLOT_W-1:0]  slot_ff;

   // Per-slot flags (reset) and counters (no reset, only read while active)
   logic [NUM_TASKS-1:0] active_ff;
   logic [NUM_TASKS-1:0] pending_ff;
   logic [COUNT_W-1:0]   ticks_ff  [NUM_TASKS];
   logic [COUNT_W-1:0]   reload_ff [NUM_TASKS];
   logic [COUNT_W-1:0]   limit_ff  [NUM_TASKS];
   logic [COUNT_W-1:0]   done_ff   [NUM_TASKS];

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [SLOT_W-1:0]  set_idx;
   logic               id_ok;
   logic [COUNT_W-1:0] period_eff;
   logic [COUNT_W-1:0] cur_ticks;
   logic [COUNT_W-1:0] cur_reload;
   logic [COUNT_W-1:0] cur_limit;
   logic [COUNT_W-1:0] cur_done;
   logic [COUNT_W-1:0] done_inc;
   logic               tick_live;
   logic               count_on;
   logic               last_fire;
   logic [MASK_W-1:0]  pend_mask;
   logic [MASK_W-1:0]  act_mask;

   // Set/unset addressing, out-of-range slots are left alone
   assign id_ok      = (32'(item_ff.task_id) < 32'(NUM_TASKS));
   assign set_idx    = SLOT_W'(item_ff.task_id);
   assign period_eff = (item_ff.period_ticks == '0) ? COUNT_W'(1) : item_ff.period_ticks;

   // Current slot of the tick walk
   assign cur_ticks  = ticks_ff[slot_ff];
   assign cur_reload = reload_ff[slot_ff];
   assign cur_limit  = limit_ff[slot_ff];
   assign cur_done   = done_ff[slot_ff];
   assign done_inc   = cur_done + COUNT_W'(1);
   assign tick_live  = active_ff[slot_ff] && !pending_ff[slot_ff];
   assign count_on   = (cur_ticks > COUNT_W'(1));
   assign last_fire  = (cur_limit != '0) && (done_inc >= cur_limit);

   // Masks cover the low slots only
   for (genvar g = 0; g < MASK_W; g++) begin : g_mask
      if (g < NUM_TASKS) begin : g_used
         assign pend_mask[g] = pending_ff[g];
         assign act_mask[g]  = active_ff[g];
      end else begin : g_unused
         assign pend_mask[g] = 1'b0;
         assign act_mask[g]  = 1'b0;
      end
   end

   // Status to controller
   assign sts.last_slot = (slot_ff == SLOT_W'(NUM_TASKS - 1));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Control state: walk counter, flags, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         active_ff    <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            slot_ff <= '0;
         end else if (cmd.tick_step) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end

         if (cmd.apply && id_ok) begin
            if (item_ff.kind == KIND_SET) begin
               active_ff[set_idx]  <= 1'b1;
               pending_ff[set_idx] <= 1'b0;
            end else begin
               active_ff[set_idx]  <= 1'b0;
               pending_ff[set_idx] <= 1'b0;
            end
         end

         // Slot fires: mark pending, drop out on the last fire
         if (cmd.tick_step && tick_live && !count_on) begin
            pending_ff[slot_ff] <= 1'b1;
            if (last_fire) begin
               active_ff[slot_ff] <= 1'b0;
            end
         end

         // Dispatch reports the old pending set and clears it
         if (cmd.finish && item_ff.kind == KIND_DISPATCH) begin
            pending_ff <= '0;
         end

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: latched request, slot counters, response data
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end

      if (cmd.apply && id_ok) begin
         if (item_ff.kind == KIND_SET) begin
            ticks_ff[set_idx]  <= period_eff;
            reload_ff[set_idx] <= period_eff;
            limit_ff[set_idx]  <= item_ff.repeat_count;
            done_ff[set_idx]   <= '0;
         end else begin
            ticks_ff[set_idx]  <= '0;
            reload_ff[set_idx] <= '0;
            limit_ff[set_idx]  <= '0;
            done_ff[set_idx]   <= '0;
         end
      end

      if (cmd.tick_step && tick_live) begin
         if (count_on) begin
            ticks_ff[slot_ff] <= cur_ticks - COUNT_W'(1);
         end else if (last_fire) begin
            ticks_ff[slot_ff]  <= '0;
            reload_ff[slot_ff] <= '0;
            limit_ff[slot_ff]  <= '0;
            done_ff[slot_ff]   <= '0;
         end else begin
            ticks_ff[slot_ff] <= cur_reload;
            if (cur_limit != '0) begin
               done_ff[slot_ff] <= done_inc;
            end
         end
      end

      if (cmd.finish) begin
         rsp_data_ff.pending_mask <= pend_mask;
         rsp_data_ff.active_mask  <= act_mask;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A loaded result is offered in the next cycle
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // Dispatch leaves no pending slot behind
   a_dispatch_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && item_ff.kind == KIND_DISPATCH) |=> (pending_ff == '0))
      else $error("pending slots survive a dispatch");

endmodule

// ----- src/periodic_task_timer_table.sv -----
// Top level of the periodic task timer table: controller and datapath.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_data  (req_type)
//   rsp     | out       | rsp_valid/rsp_ready | rsp_data  (rsp_type)
//
// One request is worked on at a time. A tick walks the slots one per cycle
// through a single counter update unit, then loads its result before the next
// request is taken. Set and unset pass through an apply state first; dispatch loads directly.
// The response register lets a new request transfer while a result waits;
// a stalled response holds the block only at the point of loading the next one.
// Synchronous active-high reset clears all slot flags and the controller.
`timescale 1ns / 1ps

module periodic_task_timer_table import ptt_pkg::*; #(
   parameter int NUM_TASKS = NUM_TASKS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ptt_cmd_type cmd;
   ptt_sts_type sts;

   // Sequencer
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Slot state and response register
   ptt_datapath #(
      .NUM_TASKS (NUM_TASKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/periodic_task_timer_table_test.sv -----
// Self-checking testbench for the periodic task timer table: directed, random and stall tests.
`timescale 1ns / 1ps

module periodic_task_timer_table_test;
   import ptt_pkg::*;

   localparam int SLOTS         = NUM_TASKS_DEFAULT;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = SLOTS + 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 150;
   localparam int TIMEOUT_NS    = 5_000_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Mirror of the timer table, advanced on every accepted transfer
   bit          slot_active  [SLOTS];
   bit          slot_pending [SLOTS];
   bit   [31:0] slot_left    [SLOTS];
   bit   [31:0] slot_period  [SLOTS];
   bit   [31:0] slot_limit   [SLOTS];
   bit   [31:0] slot_fires   [SLOTS];

   rsp_type expected_masks[$];
   int      failures       = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   bit      offering       = 1'b0;
   int      hold_requests  = 0;
   int      hold_seen      = 0;
   int      hold_left      = 0;

   periodic_task_timer_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Clear a slot's counters (unset and last fire)
   function automatic void clear_slot_counters(input int s);
      slot_left[s]   = '0;
      slot_period[s] = '0;
      slot_limit[s]  = '0;
      slot_fires[s]  = '0;
   endfunction

   // Apply one request to the mirror and return the masks it should report
   function automatic rsp_type advance_timer_table(input req_type item);
      rsp_type     result;
      bit   [31:0] period;
      int          s;
      int          id;
      id = int'(item.task_id);
      case (item.kind)
         KIND_TICK: begin
            for (s = 0; s < SLOTS; s++) begin
               if (slot_active[s] && !slot_pending[s]) begin
                  if (slot_left[s] > 32'd1) begin
                     slot_left[s]--;
                  end else begin
                     slot_pending[s] = 1'b1;
                     slot_left[s]    = slot_period[s];
                     if (slot_limit[s] != '0) begin
                        slot_fires[s]++;
                        // last fire: slot drops out, pending bit kept
                        if (slot_fires[s] >= slot_limit[s]) begin
                           slot_active[s] = 1'b0;
                           clear_slot_counters(s);
                        end
                     end
                  end
               end
            end
         end
         KIND_SET: begin
            if (id < SLOTS) begin
               period          = (item.period_ticks == '0) ? 32'd1 : item.period_ticks;
               slot_active[id]  = 1'b1;
               slot_pending[id] = 1'b0;
               slot_period[id]  = period;
               slot_left[id]    = period;
               slot_limit[id]   = item.repeat_count;
               slot_fires[id]   = '0;
            end
         end
         KIND_UNSET: begin
            if (id < SLOTS) begin
               slot_active[id]  = 1'b0;
               slot_pending[id] = 1'b0;
               clear_slot_counters(id);
            end
         end
         default: ;
      endcase
      result = '0;
      for (s = 0; s < SLOTS && s < MASK_W; s++) begin
         result.pending_mask[s] = slot_pending[s];
         result.active_mask[s]  = slot_active[s];
      end
      // dispatch reports the pending set before clearing it
      if (item.kind == KIND_DISPATCH) begin
         for (s = 0; s < SLOTS; s++) slot_pending[s] = 1'b0;
      end
      return result;
   endfunction

   function automatic req_type timer_item(input kind_type kind, input int id,
                                          input bit [31:0] reps, input bit [31:0] period);
      req_type item;
      item.kind         = kind;
      item.task_id      = id[ID_W-1:0];
      item.repeat_count = reps;
      item.period_ticks = period;
      return item;
   endfunction

   // Mostly ticks with short periods so slots fire often; ignored fields carry noise
   function automatic req_type random_timer_item();
      req_type item;
      int      pick;
      item.task_id      = ID_W'($urandom_range(7));
      item.repeat_count = $urandom;
      item.period_ticks = $urandom;
      pick = $urandom_range(99);
      if (pick < 55) begin
         item.kind = KIND_TICK;
      end else if (pick < 75) begin
         item.kind = KIND_SET;
         pick = $urandom_range(99);
         if (pick < 40)      item.repeat_count = '0;
         else if (pick < 85) item.repeat_count = $urandom_range(4, 1);
         pick = $urandom_range(99);
         if (pick < 10)      item.period_ticks = '0;
         else if (pick < 75) item.period_ticks = $urandom_range(5, 1);
         else if (pick < 90) item.period_ticks = $urandom_range(40, 6);
      end else if (pick < 83) begin
         item.kind = KIND_UNSET;
      end else begin
         item.kind = KIND_DISPATCH;
      end
      return item;
   endfunction

   task automatic release_request();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Offer one request and wait for its transfer; valid stays high afterwards
   task automatic send_timer_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         release_request();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      offering = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_masks.push_back(advance_timer_table(item));
   endtask

   // Stop offering, let every outstanding result arrive, then settle
   task automatic wait_drained();
      release_request();
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker: each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_masks.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            failures++;
         end else begin
            want = expected_masks.pop_front();
            if (rsp_data.pending_mask !== want.pending_mask) begin
               $display("%0t: pending_mask expected %h actual %h",
                        $time, want.pending_mask, rsp_data.pending_mask);
               failures++;
            end
            if (rsp_data.active_mask !== want.active_mask) begin
               $display("%0t: active_mask expected %h actual %h",
                        $time, want.active_mask, rsp_data.active_mask);
               failures++;
            end
         end
      end
   end

   // Field extremes, zero period, finite and endless slots, set and unset over pending slots
   task automatic test_directed();
      int n;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_timer_item(timer_item(KIND_DISPATCH, 7, '1, '1));
      send_timer_item(timer_item(KIND_TICK, 7, '1, '1));
      send_timer_item(timer_item(KIND_SET, 0, '0, '0));
      send_timer_item(timer_item(KIND_SET, 7, '1, '1));
      send_timer_item(timer_item(KIND_SET, 3, 32'd1, 32'd2));
      send_timer_item(timer_item(KIND_SET, 5, 32'd2, 32'd1));
      send_timer_item(timer_item(KIND_TICK, 0, '0, '0));
      send_timer_item(timer_item(KIND_TICK, 0, '0, '0));
      send_timer_item(timer_item(KIND_DISPATCH, 0, '0, '0));
      send_timer_item(timer_item(KIND_TICK, 2, '1, '1));
      send_timer_item(timer_item(KIND_UNSET, 7, '1, '1));
      send_timer_item(timer_item(KIND_SET, 0, 32'd3, 32'd4));
      send_timer_item(timer_item(KIND_UNSET, 5, '0, '0));
      send_timer_item(timer_item(KIND_DISPATCH, 4, '1, '1));
      send_timer_item(timer_item(KIND_UNSET, 2, '0, '0));
      for (n = 0; n < 4; n++) send_timer_item(timer_item(KIND_TICK, n, '0, '0));
      send_timer_item(timer_item(KIND_DISPATCH, 0, '0, '0));
      send_timer_item(timer_item(KIND_SET, 1, 32'h8000_0000, 32'h8000_0000));
      send_timer_item(timer_item(KIND_UNSET, 1, '0, '0));
      send_timer_item(timer_item(KIND_DISPATCH, 0, '0, '0));
      wait_drained();
   endtask

   // Random traffic under each idling pattern
   task automatic test_random_traffic();
      int idle_pct  [4] = '{0, 55, 0, 13};
      int stall_pct [4] = '{0, 0, 55, 13};
      int p;
      int n;
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         for (n = 0; n < PHASE_ITEMS; n++) send_timer_item(random_timer_item());
         wait_drained();
      end
   endtask

   // Long receiver hold-off while requests keep coming, so the input backs up
   task automatic test_full_backpressure();
      int n;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      for (n = 0; n < 40; n++) send_timer_item(random_timer_item());
      wait_drained();
   endtask

   // Sender stops mid-run until every result is back, then resumes
   task automatic test_paused_sender();
      int n;
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      for (n = 0; n < 20; n++) send_timer_item(random_timer_item());
      wait_drained();
      for (n = 0; n < 20; n++) send_timer_item(random_timer_item());
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_full_backpressure();
      test_paused_sender();
      if (failures == 0) begin
         $display("periodic_task_timer_table_test passed");
      end else begin
         $display("periodic_task_timer_table_test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #TIMEOUT_NS;
      $display("periodic_task_timer_table_test failed");
      $finish;
   end

endmodule
